/* hdl/bps_pkg.sv */
// ----------------------------------------------------------------------------
// bps_pkg
// shared types and constants for the bracketed port scanner
// ----------------------------------------------------------------------------
package bps_pkg;

   localparam int OFFSET_BITS_DEF = 16;
   localparam int BYTE_W          = 8;
   localparam int OFS_W           = 16;
   localparam int PORT_W          = 16;

   localparam logic [OFS_W-1:0]  MIN_TAIL_RESET = 16'd50;
   localparam logic [BYTE_W-1:0] CHAR_OPEN      = 8'h5B;
   localparam logic [BYTE_W-1:0] CHAR_CLOSE     = 8'h5D;
   localparam logic [BYTE_W-1:0] CHAR_NUL       = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_ZERO      = 8'd48;
   localparam logic [BYTE_W-1:0] CHAR_NINE      = 8'd57;
   localparam logic [PORT_W-1:0] DEC_BASE       = 16'd10;

   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NO_MATCH  = 2'd1,
      STATUS_PORT_ZERO = 2'd2,
      STATUS_TOO_SHORT = 2'd3
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
      logic [OFS_W-1:0]  search_start;
   } req_item_type;

   typedef struct packed {
      status_type        status;
      logic [OFS_W-1:0]  match_offset;
      logic [OFS_W-1:0]  match_length;
      logic [PORT_W-1:0] port_number;
   } rsp_item_type;

   typedef struct packed {
      logic advance;
      logic out_free;
   } flow_type;

endpackage

/* hdl/bps_in_stage.sv */
// ----------------------------------------------------------------------------
// bps_in_stage
// input register for one request byte; a last byte is held until the result side has room
// ----------------------------------------------------------------------------
module bps_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bps_pkg::req_item_type req_item,
   input  logic                 out_free,
   output logic                 item_valid,
   output bps_pkg::req_item_type item,
   output logic                 advance
);
   import bps_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         accept;

   assign advance   = valid_ff && (!item_ff.last_byte || out_free);
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* hdl/bps_scan_core.sv */
// ----------------------------------------------------------------------------
// bps_scan_core
// per-byte bracket scan state, port accumulation and end-of-packet verdict
// ----------------------------------------------------------------------------
module bps_scan_core #(
   parameter int OFFSET_BITS = bps_pkg::OFFSET_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [bps_pkg::OFS_W-1:0] csr_min_tail,
   input  logic                   advance,
   input  bps_pkg::req_item_type  item,
   output bps_pkg::rsp_item_type  result
);
   import bps_pkg::*;

   localparam int CMP_W = ((OFFSET_BITS + 1) > (OFS_W + 1)) ? (OFFSET_BITS + 1) : (OFS_W + 1);
   localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

   logic [OFS_W-1:0]       min_tail_ff;
   logic [OFFSET_BITS-1:0] pos_ff;
   logic                   inside_ff;
   logic [OFFSET_BITS-1:0] start_ff;
   logic                   done_ff;
   logic [OFFSET_BITS-1:0] flen_ff;
   logic [PORT_W-1:0]      acc_ff;

   logic                   inside_in;
   logic [OFFSET_BITS-1:0] start_in;
   logic                   done_in;
   logic [OFFSET_BITS-1:0] flen_in;
   logic [PORT_W-1:0]      acc_in;
   logic [OFFSET_BITS-1:0] pos_in;

   logic [CMP_W-1:0]       pkt_len;
   logic [CMP_W-1:0]       need_len;
   logic [BYTE_W-1:0]      digit;
   logic                   odd_dist;
   status_type             status;

   assign digit    = item.data_byte - CHAR_ZERO;
   assign odd_dist = pos_ff[0] ^ start_ff[0];
   assign pkt_len  = CMP_W'(pos_ff) + CMP_W'(1);
   assign need_len = CMP_W'(item.search_start) + CMP_W'(min_tail_ff);

   // scan update
   always_comb begin
      inside_in = inside_ff;
      start_in  = start_ff;
      done_in   = done_ff;
      flen_in   = flen_ff;
      acc_in    = acc_ff;
      if (!done_ff && (CMP_W'(pos_ff) >= CMP_W'(item.search_start))) begin
         if (inside_ff && (item.data_byte != CHAR_CLOSE)) begin
            if (odd_dist) begin
               if (item.data_byte != CHAR_NUL) begin
                  inside_in = 1'b0;
               end
            end else if ((item.data_byte < CHAR_ZERO) || (item.data_byte > CHAR_NINE)) begin
               inside_in = 1'b0;
            end else begin
               acc_in = (acc_ff * DEC_BASE) + PORT_W'(digit);
            end
         end
         if ((item.data_byte == CHAR_OPEN) && !inside_in) begin
            inside_in = 1'b1;
            start_in  = pos_ff;
            acc_in    = '0;
         end else if ((item.data_byte == CHAR_CLOSE) && inside_in) begin
            inside_in = 1'b0;
            done_in   = 1'b1;
            flen_in   = pos_ff - start_ff + OFFSET_BITS'(1);
         end
      end
   end

   // verdict
   always_comb begin
      priority if (pkt_len < need_len) begin
         status = STATUS_TOO_SHORT;
      end else if (!done_in) begin
         status = STATUS_NO_MATCH;
      end else if (acc_in == '0) begin
         status = STATUS_PORT_ZERO;
      end else begin
         status = STATUS_FOUND;
      end
   end

   always_comb begin
      result.status = status;
      if (status == STATUS_FOUND) begin
         result.match_offset = OFS_W'(start_in);
         result.match_length = OFS_W'(flen_in);
         result.port_number  = acc_in;
      end else begin
         result.match_offset = '0;
         result.match_length = '0;
         result.port_number  = '0;
      end
   end

   assign pos_in = (pos_ff != POS_MAX) ? (pos_ff + OFFSET_BITS'(1)) : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_tail_ff <= MIN_TAIL_RESET;
      end else if (csr_write) begin
         min_tail_ff <= csr_min_tail;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         inside_ff <= 1'b0;
         start_ff  <= '0;
         done_ff   <= 1'b0;
         flen_ff   <= '0;
         acc_ff    <= '0;
      end else if (advance) begin
         if (item.last_byte) begin
            pos_ff    <= '0;
            inside_ff <= 1'b0;
            start_ff  <= '0;
            done_ff   <= 1'b0;
            flen_ff   <= '0;
            acc_ff    <= '0;
         end else begin
            pos_ff    <= pos_in;
            inside_ff <= inside_in;
            start_ff  <= start_in;
            done_ff   <= done_in;
            flen_ff   <= flen_in;
            acc_ff    <= acc_in;
         end
      end
   end

endmodule

/* hdl/bps_out_stage.sv */
// ----------------------------------------------------------------------------
// bps_out_stage
// result register holding one response until the consumer takes it
// ----------------------------------------------------------------------------
module bps_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  bps_pkg::rsp_item_type result,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output bps_pkg::rsp_item_type rsp_item,
   output logic                  out_free
);
   import bps_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

/* hdl/bracketed_port_scanner_top.sv */
// A request is registered in the input register at acceptance; its last byte's response is
// registered in the result register when that has room, and rsp_valid rises with it.
// Throughput: one packet byte per cycle, set by the single scan stage between the
// input register and the result register; a waiting response stalls only last bytes.
// Reset clears the scan state, both stage valids and sets min_tail to 50.
// ----------------------------------------------------------------------------
// bracketed_port_scanner_top
// scans packet bytes for a bracketed wide-char decimal port and reports it
// ----------------------------------------------------------------------------
module bracketed_port_scanner_top #(
   parameter int OFFSET_BITS = bps_pkg::OFFSET_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [bps_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic                        req_last_byte,
   input  logic [bps_pkg::OFS_W-1:0]   req_search_start,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [bps_pkg::OFS_W-1:0]   rsp_match_offset,
   output logic [bps_pkg::OFS_W-1:0]   rsp_match_length,
   output logic [bps_pkg::PORT_W-1:0]  rsp_port_number,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [bps_pkg::OFS_W-1:0]   csr_min_tail
);
   import bps_pkg::*;

   req_item_type req_item;
   req_item_type item;
   rsp_item_type result;
   rsp_item_type rsp_item;
   flow_type     flow;
   logic         item_valid;
   logic         load;

   assign req_item.data_byte    = req_data_byte;
   assign req_item.last_byte    = req_last_byte;
   assign req_item.search_start = req_search_start;

   assign csr_ready = 1'b1;

   bps_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .out_free   (flow.out_free),
      .item_valid (item_valid),
      .item       (item),
      .advance    (flow.advance)
   );

   bps_scan_core #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scan_core (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_valid && csr_ready),
      .csr_min_tail (csr_min_tail),
      .advance      (flow.advance),
      .item         (item),
      .result       (result)
   );

   assign load = flow.advance && item_valid && item.last_byte;

   bps_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .out_free  (flow.out_free)
   );

   assign rsp_status       = rsp_item.status;
   assign rsp_match_offset = rsp_item.match_offset;
   assign rsp_match_length = rsp_item.match_length;
   assign rsp_port_number  = rsp_item.port_number;

endmodule

/* hdl/bps_checker.sv */
// ----------------------------------------------------------------------------
// bps_checker
// port-level checks for the bracketed port scanner
// ----------------------------------------------------------------------------
module bps_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       req_last_byte,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [1:0]                 rsp_status,
   input logic [bps_pkg::OFS_W-1:0]  rsp_match_offset,
   input logic [bps_pkg::OFS_W-1:0]  rsp_match_length,
   input logic [bps_pkg::PORT_W-1:0] rsp_port_number
);
   import bps_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_FOUND) |->
         (rsp_match_offset == '0) && (rsp_match_length == '0) && (rsp_port_number == '0))
      else $error("failed match carries nonzero fields");

   a_found_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FOUND) |-> (rsp_port_number != '0))
      else $error("found match with zero port");

   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last_byte, 2))
      else $error("response without a last byte two cycles earlier");

endmodule

bind bracketed_port_scanner_top bps_checker u_bps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_last_byte    (req_last_byte),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_match_offset (rsp_match_offset),
   .rsp_match_length (rsp_match_length),
   .rsp_port_number  (rsp_port_number)
);
